// ===== src/battery_level_hysteresis_indicator_defines.svh =====
// Assertion macros used by the battery level indicator checker
`ifndef BATTERY_LEVEL_HYSTERESIS_INDICATOR_DEFINES_SVH
`define BATTERY_LEVEL_HYSTERESIS_INDICATOR_DEFINES_SVH

// Check that a condition holds in the same cycle as its trigger
`define BLHI_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Check that a condition holds in the cycle after its trigger
`define BLHI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== src/blhi_pkg.sv =====
// Package: register codes, widths and constants of the battery level indicator
`timescale 1ns / 1ps

package blhi_pkg;

    localparam int SAMPLE_W  = 8;
    localparam int LEVEL_W   = 3;
    localparam int BRIGHT_W  = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 8;
    localparam int NUM_LEDS  = 4;
    localparam int NUM_THR   = 5;

    localparam logic [BRIGHT_W-1:0] BRIGHT_MAX = 7'd100;

    localparam logic [LEVEL_W-1:0] LEVEL_LOW  = 3'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_QUARTER = 3'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_HALF = 3'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_THREE_QUARTER = 3'd3;
    localparam logic [LEVEL_W-1:0] LEVEL_FULL = 3'd4;
    localparam logic [LEVEL_W-1:0] LEVEL_OVER = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESH_OVER          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH_FULL          = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH_THREE_QUARTER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH_HALF          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH_QUARTER       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS           = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BAR_MODE             = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_ENABLE          = 3'd7;

    // Register reset values
    localparam logic [SAMPLE_W-1:0] RST_THRESH_OVER          = 8'd210;
    localparam logic [SAMPLE_W-1:0] RST_THRESH_FULL          = 8'd195;
    localparam logic [SAMPLE_W-1:0] RST_THRESH_THREE_QUARTER = 8'd185;
    localparam logic [SAMPLE_W-1:0] RST_THRESH_HALF          = 8'd175;
    localparam logic [SAMPLE_W-1:0] RST_THRESH_QUARTER       = 8'd160;
    localparam logic [SAMPLE_W-1:0] RST_HYSTERESIS           = 8'd10;
    localparam logic                RST_BAR_MODE             = 1'b1;
    localparam logic                RST_FADE_ENABLE          = 1'b0;

    typedef logic [BRIGHT_W-1:0] bright_t;

endpackage

// ===== src/blhi_if.sv =====
// Stream interfaces for the sample and result channels
`timescale 1ns / 1ps

interface blhi_sample_if;
    logic                         valid;
    logic                         ready;
    logic [blhi_pkg::SAMPLE_W-1:0] adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface

interface blhi_result_if;
    logic                          valid;
    logic                          ready;
    logic [blhi_pkg::LEVEL_W-1:0]  level;
    logic [blhi_pkg::BRIGHT_W-1:0] led_one_level;
    logic [blhi_pkg::BRIGHT_W-1:0] led_two_level;
    logic [blhi_pkg::BRIGHT_W-1:0] led_three_level;
    logic [blhi_pkg::BRIGHT_W-1:0] led_four_level;

    modport source (output valid, output level, output led_one_level, output led_two_level,
                    output led_three_level, output led_four_level, input ready);
    modport sink   (input valid, input level, input led_one_level, input led_two_level,
                    input led_three_level, input led_four_level, output ready);
endinterface

// ===== src/battery_level_hysteresis_indicator.sv =====
// Top level: battery level detector with hysteresis and LED brightness drive
// Path: an accepted sample beat is held in the input register, and its result in the result register, which offers it.
// Throughput: one sample per cycle while the result channel is ready; the input register
// advances when it is empty or the result register advances, which it does when empty or drained.
// Reset: configuration returns to its defaults, level to over-full, the sample
// counter and all LED brightnesses to zero, and both stages empty.
`timescale 1ns / 1ps

module battery_level_hysteresis_indicator
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [blhi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [blhi_pkg::CFG_DATA_W-1:0] cfg_data,
    blhi_sample_if.sink                     in_ch,
    blhi_result_if.source                   out_ch
);
    import blhi_pkg::*;

    // Configuration registers
    logic [SAMPLE_W-1:0] thresh_over_reg;
    logic [SAMPLE_W-1:0] thresh_full_reg;
    logic [SAMPLE_W-1:0] thresh_three_quarter_reg;
    logic [SAMPLE_W-1:0] thresh_half_reg;
    logic [SAMPLE_W-1:0] thresh_quarter_reg;
    logic [SAMPLE_W-1:0] hysteresis_reg;
    logic                bar_mode_reg;
    logic                fade_enable_reg;

    // Input stage
    logic                s1_valid_reg;
    logic [SAMPLE_W-1:0] s1_sample_reg;

    // Block state
    logic [LEVEL_W-1:0]  charge_level_reg;
    logic [LEVEL_W-1:0]  charge_level_next;
    logic [7:0]          blink_count_reg;
    bright_t             led_reg [NUM_LEDS];
    bright_t             led_next [NUM_LEDS];

    // Result stage
    logic                out_valid_reg;
    logic [LEVEL_W-1:0]  out_level_reg;
    bright_t             out_led_reg [NUM_LEDS];

    logic                s2_advance;
    logic                s1_advance;
    logic                step;
    logic [SAMPLE_W-1:0] thr [NUM_THR];
    logic [NUM_LEDS-1:0] led_on;
    logic                blink;

    assign s2_advance  = !out_valid_reg || out_ch.ready;
    assign step        = s1_valid_reg && s2_advance;
    assign s1_advance  = !s1_valid_reg || s2_advance;
    assign in_ch.ready = s1_advance;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_over_reg          <= RST_THRESH_OVER;
            thresh_full_reg          <= RST_THRESH_FULL;
            thresh_three_quarter_reg <= RST_THRESH_THREE_QUARTER;
            thresh_half_reg          <= RST_THRESH_HALF;
            thresh_quarter_reg       <= RST_THRESH_QUARTER;
            hysteresis_reg           <= RST_HYSTERESIS;
            bar_mode_reg             <= RST_BAR_MODE;
            fade_enable_reg          <= RST_FADE_ENABLE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_THRESH_OVER:          thresh_over_reg          <= cfg_data;
                REG_THRESH_FULL:          thresh_full_reg          <= cfg_data;
                REG_THRESH_THREE_QUARTER: thresh_three_quarter_reg <= cfg_data;
                REG_THRESH_HALF:          thresh_half_reg          <= cfg_data;
                REG_THRESH_QUARTER:       thresh_quarter_reg       <= cfg_data;
                REG_HYSTERESIS:           hysteresis_reg           <= cfg_data;
                REG_BAR_MODE:             bar_mode_reg             <= cfg_data[0];
                REG_FADE_ENABLE:          fade_enable_reg          <= cfg_data[0];
            endcase
        end
    end

    // Capture the sample beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && in_ch.valid)
        begin
            s1_sample_reg <= in_ch.adc_sample;
        end
    end

    // Order thresholds from the bottom level up
    assign thr[0] = thresh_quarter_reg;
    assign thr[1] = thresh_half_reg;
    assign thr[2] = thresh_three_quarter_reg;
    assign thr[3] = thresh_full_reg;
    assign thr[4] = thresh_over_reg;

    // Run falling checks top down, then rising checks bottom up
    always_comb
    begin
        logic [LEVEL_W-1:0]  lvl;
        logic [SAMPLE_W:0]   rise;
        lvl = charge_level_reg;
        for (int k = NUM_THR - 1; k >= 0; k--)
        begin
            if (lvl == LEVEL_W'(k + 1) && s1_sample_reg <= thr[k])
            begin
                lvl = LEVEL_W'(k);
            end
        end
        for (int k = 0; k < NUM_THR; k++)
        begin
            rise = {1'b0, thr[k]} + {1'b0, hysteresis_reg};
            if (lvl == LEVEL_W'(k) && {1'b0, s1_sample_reg} >= rise)
            begin
                lvl = LEVEL_W'(k + 1);
            end
        end
        charge_level_next = lvl;
    end

    // Decide which LEDs are lit for the new level
    assign blink = blink_count_reg[7];

    always_comb
    begin
        led_on[0] = (charge_level_next == LEVEL_LOW) ? blink :
                    (bar_mode_reg ? (charge_level_next >= LEVEL_QUARTER)
                                  : (charge_level_next == LEVEL_QUARTER));
        led_on[1] = bar_mode_reg ? (charge_level_next >= LEVEL_HALF)
                                 : (charge_level_next == LEVEL_HALF);
        led_on[2] = bar_mode_reg ? (charge_level_next >= LEVEL_THREE_QUARTER)
                                 : (charge_level_next == LEVEL_THREE_QUARTER);
        led_on[3] = (charge_level_next == LEVEL_OVER) ? blink
                                                      : (charge_level_next == LEVEL_FULL);
    end

    // Switch or fade each LED, saturating at both ends
    always_comb
    begin
        for (int i = 0; i < NUM_LEDS; i++)
        begin
            if (!fade_enable_reg)
            begin
                led_next[i] = led_on[i] ? BRIGHT_MAX : '0;
            end
            else if (led_on[i])
            begin
                led_next[i] = (led_reg[i] < BRIGHT_MAX) ? led_reg[i] + 1'b1 : led_reg[i];
            end
            else
            begin
                led_next[i] = (led_reg[i] != '0) ? led_reg[i] - 1'b1 : '0;
            end
        end
    end

    // Advance block state once per processed sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            charge_level_reg <= LEVEL_OVER;
            blink_count_reg  <= '0;
            for (int i = 0; i < NUM_LEDS; i++)
            begin
                led_reg[i] <= '0;
            end
        end
        else if (step)
        begin
            charge_level_reg <= charge_level_next;
            blink_count_reg  <= blink_count_reg + 1'b1;
            for (int i = 0; i < NUM_LEDS; i++)
            begin
                led_reg[i] <= led_next[i];
            end
        end
    end

    // Hold the result beat until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_level_reg <= charge_level_next;
            for (int i = 0; i < NUM_LEDS; i++)
            begin
                out_led_reg[i] <= led_next[i];
            end
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.level           = out_level_reg;
    assign out_ch.led_one_level   = out_led_reg[0];
    assign out_ch.led_two_level   = out_led_reg[1];
    assign out_ch.led_three_level = out_led_reg[2];
    assign out_ch.led_four_level  = out_led_reg[3];

endmodule

// ===== src/blhi_checker.sv =====
// Port-level checker for the battery level indicator, with its bind
`timescale 1ns / 1ps
`include "battery_level_hysteresis_indicator_defines.svh"

module blhi_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [blhi_pkg::LEVEL_W-1:0]   out_level,
    input logic [blhi_pkg::BRIGHT_W-1:0]  out_led_one,
    input logic [blhi_pkg::BRIGHT_W-1:0]  out_led_two,
    input logic [blhi_pkg::BRIGHT_W-1:0]  out_led_three,
    input logic [blhi_pkg::BRIGHT_W-1:0]  out_led_four
);
    import blhi_pkg::*;

    logic [LEVEL_W+NUM_LEDS*BRIGHT_W-1:0] payload;
    logic                                 led_in_range;

    // Gather the result payload and the brightness bound
    assign payload      = {out_level, out_led_one, out_led_two, out_led_three, out_led_four};
    assign led_in_range = (out_led_one <= BRIGHT_MAX) && (out_led_two <= BRIGHT_MAX) &&
                          (out_led_three <= BRIGHT_MAX) && (out_led_four <= BRIGHT_MAX);

    // A stalled result beat stays offered
    `BLHI_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

    // A stalled result beat keeps its payload
    `BLHI_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(payload))

    // The level never leaves the six defined states
    `BLHI_ASSERT_NOW(a_level_range, clk, rst_n, out_valid, out_level <= LEVEL_OVER)

    // Brightness never exceeds full scale
    `BLHI_ASSERT_NOW(a_led_range, clk, rst_n, out_valid, led_in_range)

endmodule

bind battery_level_hysteresis_indicator blhi_checker u_blhi_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_level     (out_ch.level),
    .out_led_one   (out_ch.led_one_level),
    .out_led_two   (out_ch.led_two_level),
    .out_led_three (out_ch.led_three_level),
    .out_led_four  (out_ch.led_four_level)
);

// ===== verif/tb_top.sv =====
// Self-checking bench for the battery level indicator: random samples, live predictor.
`timescale 1ns / 1ps

module tb_top;
    import blhi_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [LEVEL_W-1:0]            level;
        bright_t [NUM_LEDS-1:0]        led;
    } indication_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    blhi_sample_if in_ch ();
    blhi_result_if out_ch ();

    battery_level_hysteresis_indicator DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Register copy and indicator state tracked by the bench
    logic [CFG_DATA_W-1:0] reg_shadow [8];
    logic [LEVEL_W-1:0]    charge_q;
    logic [7:0]            blink_q;
    bright_t               bright_q [NUM_LEDS];
    logic [5:0]            levels_seen;

    logic [SAMPLE_W-1:0]   sample_q [$];
    indication_t           indication_q [$];

    int    in_gap_max;
    int    out_stall_max;
    int    send_gap;
    int    recv_stall;
    bit    sample_took;
    int    run_left;
    int    run_base;
    int    fail_cnt;
    int    samples_sent;
    int    results_checked;
    int    settings_cnt;
    int    cycle_cnt;

    string led_name [NUM_LEDS] = '{"led_one_level", "led_two_level",
                                   "led_three_level", "led_four_level"};

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Apply one sample to the tracked state and return the indication it should produce
    function automatic indication_t advance_indicator(input logic [SAMPLE_W-1:0] s);
        logic [SAMPLE_W-1:0] thr [NUM_THR];
        logic [SAMPLE_W:0]   rise_at;
        logic [LEVEL_W-1:0]  lvl;
        logic                on [NUM_LEDS];
        logic                blink;
        logic                bar;
        logic                fade;
        indication_t         res;
        int                  k;
        thr[0] = reg_shadow[REG_THRESH_QUARTER];
        thr[1] = reg_shadow[REG_THRESH_HALF];
        thr[2] = reg_shadow[REG_THRESH_THREE_QUARTER];
        thr[3] = reg_shadow[REG_THRESH_FULL];
        thr[4] = reg_shadow[REG_THRESH_OVER];
        bar  = reg_shadow[REG_BAR_MODE][0];
        fade = reg_shadow[REG_FADE_ENABLE][0];
        blink = blink_q[7];
        lvl = charge_q;
        // Falling checks from the top down, then rising checks from the bottom up
        for (k = NUM_THR - 1; k >= 0; k--)
            if (lvl == LEVEL_W'(k + 1) && s <= thr[k])
                lvl = LEVEL_W'(k);
        for (k = 0; k < NUM_THR; k++)
        begin
            rise_at = {1'b0, thr[k]} + {1'b0, reg_shadow[REG_HYSTERESIS]};
            if (lvl == LEVEL_W'(k) && {1'b0, s} >= rise_at)
                lvl = LEVEL_W'(k + 1);
        end
        on[0] = (lvl == LEVEL_LOW) ? blink : (bar ? lvl >= LEVEL_QUARTER : lvl == LEVEL_QUARTER);
        on[1] = bar ? lvl >= LEVEL_HALF : lvl == LEVEL_HALF;
        on[2] = bar ? lvl >= LEVEL_THREE_QUARTER : lvl == LEVEL_THREE_QUARTER;
        on[3] = (lvl == LEVEL_OVER) ? blink : lvl == LEVEL_FULL;
        // Switch or fade each LED, saturating at both ends
        for (k = 0; k < NUM_LEDS; k++)
        begin
            if (!fade)
                bright_q[k] = on[k] ? BRIGHT_MAX : '0;
            else if (on[k])
            begin
                if (bright_q[k] < BRIGHT_MAX)
                    bright_q[k] = bright_q[k] + 1'b1;
            end
            else if (bright_q[k] > 0)
                bright_q[k] = bright_q[k] - 1'b1;
            res.led[k] = bright_q[k];
        end
        blink_q = blink_q + 1'b1;
        charge_q = lvl;
        levels_seen[lvl] = 1'b1;
        res.level = lvl;
        return res;
    endfunction

    function automatic int draw_wait(input int max_wait);
        if (max_wait == 0 || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(1, max_wait);
    endfunction

    function automatic int clamp_byte(input int v);
        if (v < 0)
            return 0;
        if (v > 255)
            return 255;
        return v;
    endfunction

    // Samples come in runs near a threshold, a random value or an extreme, with some noise
    function automatic logic [SAMPLE_W-1:0] next_sample();
        logic [SAMPLE_W-1:0] thr [NUM_THR];
        int                  pick;
        int                  v;
        thr[0] = reg_shadow[REG_THRESH_QUARTER];
        thr[1] = reg_shadow[REG_THRESH_HALF];
        thr[2] = reg_shadow[REG_THRESH_THREE_QUARTER];
        thr[3] = reg_shadow[REG_THRESH_FULL];
        thr[4] = reg_shadow[REG_THRESH_OVER];
        if ($urandom_range(0, 19) == 0)
            return SAMPLE_W'($urandom_range(0, 255));
        if (run_left == 0)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
                v = int'(thr[$urandom_range(0, NUM_THR - 1)]) - 3
                    + int'($urandom_range(0, int'(reg_shadow[REG_HYSTERESIS]) + 6));
            else if (pick < 8)
                v = $urandom_range(0, 255);
            else
                v = $urandom_range(0, 1) ? 255 - int'($urandom_range(0, 1))
                                         : int'($urandom_range(0, 1));
            run_base = clamp_byte(v);
            run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 220)
                                                  : $urandom_range(1, 8);
        end
        run_left--;
        v = run_base;
        if ($urandom_range(0, 3) == 0)
            v = v + int'($urandom_range(0, 4)) - 2;
        return SAMPLE_W'(clamp_byte(v));
    endfunction

    // Driver: present queued samples, hold each until accepted, then idle a random while
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid      <= 1'b0;
            in_ch.adc_sample <= '0;
            send_gap = 0;
        end
        else
        begin
            sample_took = in_ch.valid && in_ch.ready;
            if (sample_took)
            begin
                indication_q.push_back(advance_indicator(in_ch.adc_sample));
                void'(sample_q.pop_front());
                samples_sent++;
                send_gap = draw_wait(in_gap_max);
            end
            if (!in_ch.valid || sample_took)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_ch.valid <= 1'b0;
                end
                else if (sample_q.size() != 0)
                begin
                    in_ch.valid      <= 1'b1;
                    in_ch.adc_sample <= sample_q[0];
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each result beat with the oldest expected indication
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            recv_stall = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (indication_q.size() == 0)
                begin
                    $error("result beat arrived with no sample outstanding");
                    fail_cnt++;
                end
                else
                begin
                    indication_t want;
                    bright_t     got_led [NUM_LEDS];
                    want = indication_q.pop_front();
                    got_led[0] = out_ch.led_one_level;
                    got_led[1] = out_ch.led_two_level;
                    got_led[2] = out_ch.led_three_level;
                    got_led[3] = out_ch.led_four_level;
                    if (out_ch.level !== want.level)
                    begin
                        $error("level: expected %0d, got %0d", want.level, out_ch.level);
                        fail_cnt++;
                    end
                    for (int i = 0; i < NUM_LEDS; i++)
                        if (got_led[i] !== want.led[i])
                        begin
                            $error("%s: expected %0d, got %0d", led_name[i], want.led[i],
                                   got_led[i]);
                            fail_cnt++;
                        end
                    results_checked++;
                end
                recv_stall = draw_wait(out_stall_max);
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == REG_BAR_MODE || idx == REG_FADE_ENABLE)
            reg_shadow[idx] = val & 8'h01;
        else
            reg_shadow[idx] = val;
    endtask

    task automatic program_regs(input logic [7:0] t_over, input logic [7:0] t_full,
                                input logic [7:0] t_tq, input logic [7:0] t_half,
                                input logic [7:0] t_quarter, input logic [7:0] hyst,
                                input logic [7:0] bar_v, input logic [7:0] fade_v);
        write_reg(REG_THRESH_OVER, t_over);
        write_reg(REG_THRESH_FULL, t_full);
        write_reg(REG_THRESH_THREE_QUARTER, t_tq);
        write_reg(REG_THRESH_HALF, t_half);
        write_reg(REG_THRESH_QUARTER, t_quarter);
        write_reg(REG_HYSTERESIS, hyst);
        write_reg(REG_BAR_MODE, bar_v);
        write_reg(REG_FADE_ENABLE, fade_v);
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_cnt++;
    endtask

    // Random thresholds, half the time in their natural order; mode bits carry junk upper bits
    task automatic program_random();
        int vals [5];
        int hyst;
        foreach (vals[i])
            vals[i] = $urandom_range(0, 255);
        if ($urandom_range(0, 1))
            vals.rsort();
        hyst = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 24);
        program_regs(8'(vals[0]), 8'(vals[1]), 8'(vals[2]), 8'(vals[3]), 8'(vals[4]),
                     8'(hyst), 8'($urandom), 8'($urandom));
    endtask

    // Wait until every sample is accepted and every result checked, then let the pipe settle
    task automatic wait_drained();
        @(posedge clk);
        while (sample_q.size() != 0 || in_ch.valid || indication_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input int n, input int gap_in, input int gap_out);
        in_gap_max    = gap_in;
        out_stall_max = gap_out;
        run_left      = 0;
        repeat (n) sample_q.push_back(next_sample());
        wait_drained();
    endtask

    initial
    begin
        logic [SAMPLE_W-1:0] walk [];
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        in_ch.valid      = 1'b0;
        in_ch.adc_sample = '0;
        out_ch.ready     = 1'b0;
        reg_shadow[REG_THRESH_OVER]          = RST_THRESH_OVER;
        reg_shadow[REG_THRESH_FULL]          = RST_THRESH_FULL;
        reg_shadow[REG_THRESH_THREE_QUARTER] = RST_THRESH_THREE_QUARTER;
        reg_shadow[REG_THRESH_HALF]          = RST_THRESH_HALF;
        reg_shadow[REG_THRESH_QUARTER]       = RST_THRESH_QUARTER;
        reg_shadow[REG_HYSTERESIS]           = RST_HYSTERESIS;
        reg_shadow[REG_BAR_MODE]             = 8'(RST_BAR_MODE);
        reg_shadow[REG_FADE_ENABLE]          = 8'(RST_FADE_ENABLE);
        charge_q    = LEVEL_OVER;
        blink_q     = '0;
        foreach (bright_q[i])
            bright_q[i] = '0;
        levels_seen = '0;
        in_gap_max    = 16;
        out_stall_max = 16;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Walk each threshold at its edges with reset settings, plus full-scale swings
        walk = '{8'd255, 8'd211, 8'd210, 8'd205, 8'd204, 8'd196, 8'd195, 8'd194, 8'd186,
                 8'd185, 8'd176, 8'd175, 8'd161, 8'd160, 8'd159, 8'd170, 8'd169, 8'd0,
                 8'd255, 8'd0, 8'd1, 8'd254, 8'd128, 8'd127};
        foreach (walk[i])
            sample_q.push_back(walk[i]);
        wait_drained();

        program_regs(RST_THRESH_OVER, RST_THRESH_FULL, RST_THRESH_THREE_QUARTER,
                     RST_THRESH_HALF, RST_THRESH_QUARTER, RST_HYSTERESIS, 8'd0, 8'd0);
        run_phase(140, 0, 0);
        program_regs(RST_THRESH_OVER, RST_THRESH_FULL, RST_THRESH_THREE_QUARTER,
                     RST_THRESH_HALF, RST_THRESH_QUARTER, RST_HYSTERESIS, 8'd1, 8'd1);
        run_phase(160, 16, 16);
        program_regs(RST_THRESH_OVER, RST_THRESH_FULL, RST_THRESH_THREE_QUARTER,
                     RST_THRESH_HALF, RST_THRESH_QUARTER, RST_HYSTERESIS, 8'd0, 8'd1);
        run_phase(160, 16, 0);
        // Rising sums past 255: the level can only fall
        program_regs(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd1, 8'd0);
        run_phase(60, 0, 16);
        // All thresholds at zero with no margin
        program_regs(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1);
        run_phase(60, 16, 16);
        // Rise only at a full-scale sample
        program_regs(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd1, 8'd1);
        run_phase(80, 8, 8);
        repeat (4)
        begin
            program_random();
            run_phase(120, $urandom_range(0, 1) * 16, $urandom_range(0, 1) * 16);
        end

        if (indication_q.size() != 0)
        begin
            $error("%0d expected results never arrived", indication_q.size());
            fail_cnt++;
        end
        $display("Sent %0d samples, checked %0d results across %0d register settings.",
                 samples_sent, results_checked, settings_cnt);
        $display("Charge levels reached (bit per level): %b", levels_seen);
        if (fail_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
